### rtl/kd_tree_leaf_search_defines.svh
// ----------------------------------------------------------------------------
// kd_tree_leaf_search_defines
// Assertion macros shared by the kd-tree leaf search RTL.
// ----------------------------------------------------------------------------
`ifndef KD_TREE_LEAF_SEARCH_DEFINES_SVH
`define KD_TREE_LEAF_SEARCH_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define KDLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define KDLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kdls_pkg.sv
// ----------------------------------------------------------------------------
// kdls_pkg
// Constants, codes and types of the kd-tree leaf search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdls_pkg;

    localparam int LEVELS     = 10;
    localparam int DIM        = 64;
    localparam int VALUE_BITS = 32;

    localparam int NODE_COUNT = (2 ** LEVELS) - 1;
    localparam int NODE_AW    = LEVELS;
    localparam int FEAT_AW    = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int LEVEL_W    = $clog2(LEVELS + 1);

    localparam int MODE_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int COMP_W   = 6;
    localparam int IN_VAL_W = 32;
    localparam int LEAF_W   = 10;
    localparam int STEPS_W  = 4;
    localparam int TL_W     = 4;
    localparam int MD_W     = 5;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 5;

    localparam logic [TL_W-1:0] TREE_LEVELS_RST = TL_W'(10);
    localparam logic [MD_W-1:0] MAX_DEPTH_RST   = MD_W'(0);

    typedef enum logic [MODE_W-1:0] {
        MODE_NODE = 2'd0,
        MODE_FEAT = 2'd1,
        MODE_EVAL = 2'd2
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TREE_LEVELS = 1'd0,
        CFG_MAX_DEPTH   = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FEAT,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [COMP_W-1:0]            comp;
        logic signed [VALUE_BITS-1:0] plane;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic               node_re;
        logic [NODE_AW-1:0] node_addr;
        logic               feat_re;
        logic [FEAT_AW-1:0] feat_addr;
    } t_rd_req;

endpackage

### rtl/kdls_ram.sv
// ----------------------------------------------------------------------------
// kdls_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/kdls_seq.sv
// ----------------------------------------------------------------------------
// kdls_seq
// Descent sequencer: one node read, one feature read and one compare per level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kd_tree_leaf_search_defines.svh"

module kdls_seq (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start_eval,
    input  logic [kdls_pkg::TL_W-1:0]             i_tree_levels,
    input  logic [kdls_pkg::MD_W-1:0]             i_max_depth,
    input  kdls_pkg::t_node                       i_node_rdata,
    input  logic signed [kdls_pkg::VALUE_BITS-1:0] i_feat_rdata,
    output kdls_pkg::t_rd_req                     o_rd_req,
    output logic                                  o_busy,
    output logic                                  o_valid,
    output logic [kdls_pkg::LEAF_W-1:0]           o_leaf_index,
    output logic [kdls_pkg::STEPS_W-1:0]          o_steps_taken
);

    kdls_pkg::t_state r_state, n_state;

    logic [kdls_pkg::NODE_AW-1:0]         r_node,  n_node;
    logic [kdls_pkg::LEVEL_W-1:0]         r_level, n_level;
    logic [kdls_pkg::STEPS_W-1:0]         r_steps, n_steps;
    logic signed [kdls_pkg::VALUE_BITS-1:0] r_plane, n_plane;
    logic                                 r_oob,   n_oob;

    logic [kdls_pkg::LEVEL_W-1:0]         w_level_init;
    logic                                 w_stop;
    logic signed [kdls_pkg::VALUE_BITS-1:0] w_feat;
    logic                                 w_left;

    // clamp tree size into 1..LEVELS
    always_comb begin
        if (i_tree_levels == '0) begin
            w_level_init = kdls_pkg::LEVEL_W'(1);
        end else if (32'(i_tree_levels) > kdls_pkg::LEVELS) begin
            w_level_init = kdls_pkg::LEVEL_W'(kdls_pkg::LEVELS);
        end else begin
            w_level_init = kdls_pkg::LEVEL_W'(i_tree_levels);
        end
    end

    assign w_stop = (r_level <= kdls_pkg::LEVEL_W'(1))
        || ((i_max_depth != '0)
            && ((kdls_pkg::MD_W'(r_steps) + kdls_pkg::MD_W'(1)) >= i_max_depth))
        || (r_node == kdls_pkg::NODE_AW'(kdls_pkg::NODE_COUNT));

    assign w_feat = r_oob ? '0 : i_feat_rdata;
    assign w_left = (w_feat < r_plane);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kdls_pkg::S_IDLE: begin
                if (i_start_eval) begin
                    n_state = kdls_pkg::S_CHECK;
                end
            end
            kdls_pkg::S_CHECK: begin
                n_state = w_stop ? kdls_pkg::S_DONE : kdls_pkg::S_FEAT;
            end
            kdls_pkg::S_FEAT: n_state = kdls_pkg::S_CMP;
            kdls_pkg::S_CMP:  n_state = kdls_pkg::S_CHECK;
            kdls_pkg::S_DONE: n_state = kdls_pkg::S_IDLE;
            default:          n_state = kdls_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rd_req           = '0;
        o_rd_req.node_addr = r_node;
        o_rd_req.feat_addr = kdls_pkg::FEAT_AW'(i_node_rdata.comp);
        o_busy             = 1'b1;
        o_valid            = 1'b0;
        case (r_state)
            kdls_pkg::S_IDLE:  o_busy = 1'b0;
            kdls_pkg::S_CHECK: o_rd_req.node_re = ~w_stop;
            kdls_pkg::S_FEAT:  o_rd_req.feat_re = 1'b1;
            kdls_pkg::S_CMP:   o_busy = 1'b1;
            kdls_pkg::S_DONE:  o_valid = 1'b1;
            default:           o_busy = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        n_node  = r_node;
        n_level = r_level;
        n_steps = r_steps;
        n_plane = r_plane;
        n_oob   = r_oob;
        case (r_state)
            kdls_pkg::S_IDLE: begin
                n_node  = '0;
                n_level = w_level_init;
                n_steps = '0;
            end
            kdls_pkg::S_FEAT: begin
                n_plane = i_node_rdata.plane;
                n_oob   = (32'(i_node_rdata.comp) >= kdls_pkg::DIM);
            end
            kdls_pkg::S_CMP: begin
                n_node = w_left ? (r_node + kdls_pkg::NODE_AW'(1))
                                : (r_node + (kdls_pkg::NODE_AW'(1)
                                             << (r_level - kdls_pkg::LEVEL_W'(1))));
                n_level = r_level - kdls_pkg::LEVEL_W'(1);
                n_steps = r_steps + kdls_pkg::STEPS_W'(1);
            end
            default: begin
                n_node = r_node;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kdls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node  <= n_node;
        r_level <= n_level;
        r_steps <= n_steps;
        r_plane <= n_plane;
        r_oob   <= n_oob;
    end

    assign o_leaf_index  = kdls_pkg::LEAF_W'(r_node);
    assign o_steps_taken = r_steps;

    `KDLS_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "result strobe held longer than one cycle")
    `KDLS_ASSERT_NEXT(a_start_busy, i_start_eval, o_busy, "evaluation request did not raise busy")
    `KDLS_ASSERT_NEXT(a_step_count, r_state == kdls_pkg::S_CMP, r_steps == $past(r_steps) + kdls_pkg::STEPS_W'(1), "step count not advanced by compare")
    `KDLS_ASSERT_SAME(a_steps_bound, o_valid, 32'(o_steps_taken) < kdls_pkg::LEVELS, "step count exceeds tree depth")

endmodule

### rtl/kd_tree_leaf_search.sv
// An accepted evaluation steps the sequencer through check, feature and compare states for each
// of its k comparisons (at most LEVELS-1 = 9), then a last check and the strobing done state; busy
// stays high until the strobe cycle ends, and no request is taken while busy is high. Each level
// costs one node RAM read, one feature RAM read and one compare. Writes go one per cycle while not busy.
// Reset (synchronous, active low) clears the sequencer, tree_levels to 10, max_depth to 0;
// node and feature stores hold nothing defined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
// kd_tree_leaf_search
// Leaf search in a full balanced kd-tree stored in depth-first order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kd_tree_leaf_search (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kdls_pkg::CFG_AW-1:0]          i_cfg_idx,
    input  logic [kdls_pkg::CFG_DW-1:0]          i_cfg_wdata,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [kdls_pkg::MODE_W-1:0]          i_mode,
    input  logic [kdls_pkg::INDEX_W-1:0]         i_index,
    input  logic [kdls_pkg::COMP_W-1:0]          i_comp,
    input  logic signed [kdls_pkg::IN_VAL_W-1:0] i_value,
    output logic                                 o_valid,
    output logic [kdls_pkg::LEAF_W-1:0]          o_leaf_index,
    output logic [kdls_pkg::STEPS_W-1:0]         o_steps_taken
);

    logic [kdls_pkg::TL_W-1:0] r_tree_levels;
    logic [kdls_pkg::MD_W-1:0] r_max_depth;

    logic                                  w_accept;
    logic                                  w_node_we;
    logic                                  w_feat_we;
    logic                                  w_start_eval;
    kdls_pkg::t_node                       w_node_wdata;
    kdls_pkg::t_node                       w_node_rdata;
    logic signed [kdls_pkg::VALUE_BITS-1:0] w_feat_rdata;
    kdls_pkg::t_rd_req                     w_rd_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_levels <= kdls_pkg::TREE_LEVELS_RST;
            r_max_depth   <= kdls_pkg::MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kdls_pkg::CFG_TREE_LEVELS: r_tree_levels <= kdls_pkg::TL_W'(i_cfg_wdata);
                kdls_pkg::CFG_MAX_DEPTH:   r_max_depth   <= kdls_pkg::MD_W'(i_cfg_wdata);
                default:                   r_max_depth   <= r_max_depth;
            endcase
        end
    end

    assign w_accept     = i_start && !o_busy;
    assign w_node_we    = w_accept && (i_mode == kdls_pkg::MODE_NODE)
                          && (32'(i_index) < kdls_pkg::NODE_COUNT);
    assign w_feat_we    = w_accept && (i_mode == kdls_pkg::MODE_FEAT)
                          && (32'(i_index) < kdls_pkg::DIM);
    assign w_start_eval = w_accept && (i_mode == kdls_pkg::MODE_EVAL);

    assign w_node_wdata.comp  = i_comp;
    assign w_node_wdata.plane = i_value[kdls_pkg::VALUE_BITS-1:0];

    kdls_ram #(
        .WIDTH (kdls_pkg::NODE_W),
        .DEPTH (kdls_pkg::NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_we),
        .i_waddr (kdls_pkg::NODE_AW'(i_index)),
        .i_wdata (w_node_wdata),
        .i_re    (w_rd_req.node_re),
        .i_raddr (w_rd_req.node_addr),
        .o_rdata (w_node_rdata)
    );

    kdls_ram #(
        .WIDTH (kdls_pkg::VALUE_BITS),
        .DEPTH (kdls_pkg::DIM)
    ) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (w_feat_we),
        .i_waddr (kdls_pkg::FEAT_AW'(i_index)),
        .i_wdata (i_value[kdls_pkg::VALUE_BITS-1:0]),
        .i_re    (w_rd_req.feat_re),
        .i_raddr (w_rd_req.feat_addr),
        .o_rdata (w_feat_rdata)
    );

    kdls_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_eval  (w_start_eval),
        .i_tree_levels (r_tree_levels),
        .i_max_depth   (r_max_depth),
        .i_node_rdata  (w_node_rdata),
        .i_feat_rdata  (w_feat_rdata),
        .o_rd_req      (w_rd_req),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_leaf_index  (o_leaf_index),
        .o_steps_taken (o_steps_taken)
    );

endmodule

### bench/kdls_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdls_result_checker
// Watches the request, register and result ports of the kd-tree leaf search
// block, keeps its own copy of the tree, feature vector and registers, and
// compares every result against the predicted leaf and comparison count.
// ----------------------------------------------------------------------------

module kdls_result_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kdls_pkg::CFG_AW-1:0]          i_cfg_idx,
    input  logic [kdls_pkg::CFG_DW-1:0]          i_cfg_wdata,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic [kdls_pkg::MODE_W-1:0]          i_mode,
    input  logic [kdls_pkg::INDEX_W-1:0]         i_index,
    input  logic [kdls_pkg::COMP_W-1:0]          i_comp,
    input  logic signed [kdls_pkg::IN_VAL_W-1:0] i_value,
    input  logic                                 i_valid,
    input  logic [kdls_pkg::LEAF_W-1:0]          i_leaf_index,
    input  logic [kdls_pkg::STEPS_W-1:0]         i_steps_taken,
    output int                                   o_errors,
    output int                                   o_pending
);

    typedef struct packed {
        logic [kdls_pkg::LEAF_W-1:0]  leaf;
        logic [kdls_pkg::STEPS_W-1:0] steps;
    } t_leaf_result;

    logic [kdls_pkg::COMP_W-1:0]            node_comp_mem  [kdls_pkg::NODE_COUNT];
    logic signed [kdls_pkg::VALUE_BITS-1:0] node_split_mem [kdls_pkg::NODE_COUNT];
    logic signed [kdls_pkg::VALUE_BITS-1:0] feature_mem    [kdls_pkg::DIM];
    logic [kdls_pkg::TL_W-1:0]              tree_levels_q;
    logic [kdls_pkg::MD_W-1:0]              max_depth_q;
    t_leaf_result                           expected_leaves [$];
    int                                     err_count = 0;
    int                                     open_count = 0;

    assign o_errors  = err_count;
    assign o_pending = open_count;

    function automatic t_leaf_result descend_tree();
        int unsigned                            lvl;
        int unsigned                            node;
        int unsigned                            nsteps;
        logic                                   stop;
        logic signed [kdls_pkg::VALUE_BITS-1:0] fval;
        t_leaf_result                           res;
        lvl = tree_levels_q;
        if (lvl < 1) lvl = 1;
        if (lvl > kdls_pkg::LEVELS) lvl = kdls_pkg::LEVELS;
        node   = 0;
        nsteps = 0;
        stop   = 1'b0;
        while (lvl > 1 && !stop) begin
            if ((max_depth_q != 0 && nsteps + 1 >= max_depth_q)
                    || node >= kdls_pkg::NODE_COUNT) begin
                stop = 1'b1;
            end else begin
                if (node_comp_mem[node] < kdls_pkg::DIM) begin
                    fval = feature_mem[node_comp_mem[node]];
                end else begin
                    fval = '0;
                end
                if (fval < node_split_mem[node]) begin
                    node = node + 1;
                end else begin
                    node = node + (1 << (lvl - 1));
                end
                lvl    = lvl - 1;
                nsteps = nsteps + 1;
            end
        end
        res.leaf  = kdls_pkg::LEAF_W'(node);
        res.steps = kdls_pkg::STEPS_W'(nsteps);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_leaf_result want;
        if (!i_rst_n) begin
            tree_levels_q = kdls_pkg::TREE_LEVELS_RST;
            max_depth_q   = kdls_pkg::MAX_DEPTH_RST;
            expected_leaves.delete();
            open_count = 0;
        end else begin
            if (i_valid) begin
                if (expected_leaves.size() == 0) begin
                    err_count++;
                    $display("%0t: result with no request open: expected none, actual leaf %0d steps %0d",
                             $time, i_leaf_index, i_steps_taken);
                end else begin
                    want = expected_leaves.pop_front();
                    if (i_leaf_index !== want.leaf) begin
                        err_count++;
                        $display("%0t: leaf_index mismatch: expected %0d, actual %0d",
                                 $time, want.leaf, i_leaf_index);
                    end
                    if (i_steps_taken !== want.steps) begin
                        err_count++;
                        $display("%0t: steps_taken mismatch: expected %0d, actual %0d",
                                 $time, want.steps, i_steps_taken);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == kdls_pkg::CFG_TREE_LEVELS) begin
                    tree_levels_q = i_cfg_wdata[kdls_pkg::TL_W-1:0];
                end else if (i_cfg_idx == kdls_pkg::CFG_MAX_DEPTH) begin
                    max_depth_q = i_cfg_wdata[kdls_pkg::MD_W-1:0];
                end
            end
            if (i_start && !i_busy) begin
                case (i_mode)
                    kdls_pkg::MODE_NODE: begin
                        if (i_index < kdls_pkg::NODE_COUNT) begin
                            node_comp_mem[i_index]  = i_comp;
                            node_split_mem[i_index] = i_value[kdls_pkg::VALUE_BITS-1:0];
                        end
                    end
                    kdls_pkg::MODE_FEAT: begin
                        if (i_index < kdls_pkg::DIM) begin
                            feature_mem[i_index] = i_value[kdls_pkg::VALUE_BITS-1:0];
                        end
                    end
                    kdls_pkg::MODE_EVAL: begin
                        expected_leaves.push_back(descend_tree());
                    end
                    default: ;
                endcase
            end
            open_count = expected_leaves.size();
        end
    end

endmodule

### bench/tb_kd_tree_leaf_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kd_tree_leaf_search
// Fills the whole tree and feature vector, runs a short set of directed
// requests, then random requests in bursts across several register settings.
// Results are checked by kdls_result_checker; this module drives and decides.
// ----------------------------------------------------------------------------

module tb_kd_tree_leaf_search;

    localparam logic [kdls_pkg::MODE_W-1:0] MODE_UNUSED   = 2'd3;
    localparam int                          SETTLE_CYCLES = 40;
    localparam int                          PHASE_ITEMS   = 78;
    localparam int                          NUM_PHASES    = 11;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_cfg_we;
    logic [kdls_pkg::CFG_AW-1:0]            i_cfg_idx;
    logic [kdls_pkg::CFG_DW-1:0]            i_cfg_wdata;
    logic                                   i_start;
    logic                                   o_busy;
    logic [kdls_pkg::MODE_W-1:0]            i_mode;
    logic [kdls_pkg::INDEX_W-1:0]           i_index;
    logic [kdls_pkg::COMP_W-1:0]            i_comp;
    logic signed [kdls_pkg::IN_VAL_W-1:0]   i_value;
    logic                                   o_valid;
    logic [kdls_pkg::LEAF_W-1:0]            o_leaf_index;
    logic [kdls_pkg::STEPS_W-1:0]           o_steps_taken;
    int                                     error_total;
    int                                     open_results;

    // tree_levels / max_depth per phase; the last ones are drawn at random
    int unsigned levels_set [NUM_PHASES] = '{1, 0, 15, 10, 10, 10, 10, 5, 3, 0, 0};
    int unsigned depth_set  [NUM_PHASES] = '{0, 3, 0, 31, 16, 1, 2, 4, 0, 0, 0};

    kd_tree_leaf_search uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_comp        (i_comp),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_leaf_index  (o_leaf_index),
        .o_steps_taken (o_steps_taken)
    );

    kdls_result_checker leaf_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_mode        (i_mode),
        .i_index       (i_index),
        .i_comp        (i_comp),
        .i_value       (i_value),
        .i_valid       (o_valid),
        .i_leaf_index  (o_leaf_index),
        .i_steps_taken (o_steps_taken),
        .o_errors      (error_total),
        .o_pending     (open_results)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [kdls_pkg::COMP_W-1:0] pick_comp();
        if ($urandom_range(0, 9) < 4) return kdls_pkg::COMP_W'($urandom_range(0, 7));
        return kdls_pkg::COMP_W'($urandom);
    endfunction

    // Drive one request at the falling edge and hold it until accepted.
    task automatic send_request(input logic [kdls_pkg::MODE_W-1:0] mode,
                                input logic [kdls_pkg::INDEX_W-1:0] index,
                                input logic [kdls_pkg::COMP_W-1:0] comp,
                                input logic [31:0] value);
        @(negedge i_clk);
        i_start = 1'b1;
        i_mode  = mode;
        i_index = index;
        i_comp  = comp;
        i_value = value;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
    endtask

    task automatic send_random_item();
        int unsigned                   pick;
        int unsigned                   sub;
        logic [kdls_pkg::INDEX_W-1:0]  idx;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        if (pick < 40) begin
            send_request(kdls_pkg::MODE_EVAL, kdls_pkg::INDEX_W'($urandom),
                         kdls_pkg::COMP_W'($urandom), $urandom);
        end else if (pick < 65) begin
            if (sub == 0)     idx = kdls_pkg::INDEX_W'($urandom_range(kdls_pkg::DIM, 1023));
            else if (sub < 4) idx = kdls_pkg::INDEX_W'($urandom_range(0, 7));
            else              idx = kdls_pkg::INDEX_W'($urandom_range(0, kdls_pkg::DIM - 1));
            send_request(kdls_pkg::MODE_FEAT, idx, kdls_pkg::COMP_W'($urandom), pick_value());
        end else if (pick < 92) begin
            if (sub == 0)     idx = 10'd1023;
            else if (sub < 4) idx = kdls_pkg::INDEX_W'($urandom_range(0, 15));
            else if (sub < 6) idx = kdls_pkg::INDEX_W'(1 << $urandom_range(0, kdls_pkg::LEVELS - 1));
            else              idx = kdls_pkg::INDEX_W'($urandom_range(0, kdls_pkg::NODE_COUNT - 1));
            send_request(kdls_pkg::MODE_NODE, idx, pick_comp(), pick_value());
        end else begin
            send_request(MODE_UNUSED, kdls_pkg::INDEX_W'($urandom),
                         kdls_pkg::COMP_W'($urandom), $urandom);
        end
    endtask

    task automatic run_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_random_item();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    // Wait until no evaluation is open and busy is low, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (open_results != 0 || o_busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned levels, input int unsigned depth);
        drain();
        i_cfg_we    = 1'b1;
        i_cfg_idx   = kdls_pkg::CFG_TREE_LEVELS;
        i_cfg_wdata = {1'($urandom_range(0, 1)), kdls_pkg::TL_W'(levels)};
        @(negedge i_clk);
        i_cfg_idx   = kdls_pkg::CFG_MAX_DEPTH;
        i_cfg_wdata = kdls_pkg::MD_W'(depth);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = kdls_pkg::CFG_TREE_LEVELS;
        i_cfg_wdata = '0;
        i_start     = 1'b0;
        i_mode      = kdls_pkg::MODE_NODE;
        i_index     = '0;
        i_comp      = '0;
        i_value     = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fill every node and feature entry so no read ever hits an unwritten one
        for (int n = 0; n < kdls_pkg::NODE_COUNT; n++) begin
            send_request(kdls_pkg::MODE_NODE, kdls_pkg::INDEX_W'(n), pick_comp(), pick_value());
        end
        for (int f = 0; f < kdls_pkg::DIM; f++) begin
            send_request(kdls_pkg::MODE_FEAT, kdls_pkg::INDEX_W'(f),
                         kdls_pkg::COMP_W'($urandom), pick_value());
        end

        // directed: value extremes, ties, ignored writes, unused mode
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);
        send_request(kdls_pkg::MODE_FEAT, 10'd5, 6'd0, 32'h8000_0000);
        send_request(kdls_pkg::MODE_NODE, 10'd0, 6'd5, 32'h7fff_ffff);
        send_request(kdls_pkg::MODE_EVAL, 10'h3ff, 6'h3f, 32'hffff_ffff);
        send_request(kdls_pkg::MODE_FEAT, 10'd5, 6'd0, 32'h7fff_ffff);
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);
        send_request(kdls_pkg::MODE_NODE, 10'd0, 6'd63, 32'h8000_0000);
        send_request(kdls_pkg::MODE_FEAT, 10'd63, 6'd0, 32'h8000_0000);
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);
        send_request(kdls_pkg::MODE_FEAT, 10'd63, 6'd0, 32'h7fff_ffff);
        send_request(kdls_pkg::MODE_NODE, 10'd1023, 6'd0, 32'h0000_0000);
        send_request(kdls_pkg::MODE_FEAT, 10'd64, 6'd0, 32'h0000_0000);
        send_request(kdls_pkg::MODE_FEAT, 10'd1023, 6'h3f, 32'h5555_5555);
        send_request(MODE_UNUSED, 10'h3ff, 6'h3f, 32'hffff_ffff);
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);
        send_request(kdls_pkg::MODE_NODE, 10'd1022, 6'd63, 32'hffff_ffff);
        send_request(kdls_pkg::MODE_FEAT, 10'd0, 6'd0, 32'h0000_0000);
        send_request(kdls_pkg::MODE_NODE, 10'd512, 6'd0, 32'h0000_0000);
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);
        send_request(kdls_pkg::MODE_NODE, 10'd512, 6'd0, 32'h0000_0001);
        send_request(kdls_pkg::MODE_EVAL, '0, '0, '0);

        run_random(PHASE_ITEMS);
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= NUM_PHASES - 2) begin
                set_config($urandom_range(0, 15), $urandom_range(0, 31));
            end else begin
                set_config(levels_set[p], depth_set[p]);
            end
            run_random(PHASE_ITEMS);
        end

        drain();
        if (error_total == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
